// File: hw/rtl/gcd_pkg.sv
// Shared types, codes and denomination constants for the greedy change dispenser.
// Used by gcd_cell and greedy_change_dispenser; depends on nothing else.
package gcd_pkg;

  // Field widths
  localparam int COUNT_BITS  = 16;
  localparam int AMOUNT_BITS = 20;
  localparam int SLOT_BITS   = 4;
  localparam int STATUS_BITS = 3;
  localparam int DENOM_BITS  = 13;
  localparam int NUM_SLOTS   = 11;

  // Width of count * denomination, and a working width that holds every operand
  localparam int CD_BITS   = COUNT_BITS + DENOM_BITS;
  localparam int WIDE_BITS = (CD_BITS > AMOUNT_BITS) ? CD_BITS : AMOUNT_BITS;

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_SLOTS - 1);

  // Request codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_CHANGE = 1'b1;

  // Status codes
  localparam logic [STATUS_BITS-1:0] STATUS_EXACT     = 3'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 3'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_LACKING   = 3'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_UNDERPAID = 3'd3;
  localparam logic [STATUS_BITS-1:0] STATUS_LOADED    = 3'd4;

  // Denominations in pence, largest first
  localparam logic [DENOM_BITS-1:0] DENOM [NUM_SLOTS] = '{
    13'd5000, 13'd2000, 13'd1000, 13'd500, 13'd100, 13'd50,
    13'd20, 13'd10, 13'd5, 13'd2, 13'd1
  };

  // Reciprocals floor((2^AMOUNT_BITS - 1) / d); the estimate is low by at most one
  localparam logic [63:0] AMOUNT_FULL = (64'd1 << AMOUNT_BITS) - 64'd1;
  localparam logic [AMOUNT_BITS-1:0] RECIP [NUM_SLOTS] = '{
    AMOUNT_BITS'(AMOUNT_FULL / 64'd5000), AMOUNT_BITS'(AMOUNT_FULL / 64'd2000),
    AMOUNT_BITS'(AMOUNT_FULL / 64'd1000), AMOUNT_BITS'(AMOUNT_FULL / 64'd500),
    AMOUNT_BITS'(AMOUNT_FULL / 64'd100),  AMOUNT_BITS'(AMOUNT_FULL / 64'd50),
    AMOUNT_BITS'(AMOUNT_FULL / 64'd20),   AMOUNT_BITS'(AMOUNT_FULL / 64'd10),
    AMOUNT_BITS'(AMOUNT_FULL / 64'd5),    AMOUNT_BITS'(AMOUNT_FULL / 64'd2),
    AMOUNT_BITS'(AMOUNT_FULL / 64'd1)
  };

  // Input word
  typedef struct packed {
    logic                   func;
    logic [SLOT_BITS-1:0]   slot;
    logic [COUNT_BITS-1:0]  count;
    logic [AMOUNT_BITS-1:0] owed;
    logic [AMOUNT_BITS-1:0] offered;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [SLOT_BITS-1:0]   denom_slot;
    logic [COUNT_BITS-1:0]  pieces;
    logic                   last;
    logic [STATUS_BITS-1:0] status;
    logic [AMOUNT_BITS-1:0] credit;
  } out_word_t;

  // Remaining amount handed from cell to cell
  typedef struct packed {
    logic                   go;
    logic [AMOUNT_BITS-1:0] rem;
  } wave_t;

  // Till slot load command
  typedef struct packed {
    logic                  en;
    logic [COUNT_BITS-1:0] count;
  } load_t;

  // Top-level sequencer
  typedef enum logic {
    S_IDLE,
    S_RUN
  } run_state_t;

endpackage

// File: hw/rtl/gcd_cell.sv
// One till slot: holds its piece count and pays its share of the remaining amount.
// Depends on gcd_pkg; instantiated once per denomination by greedy_change_dispenser.
module gcd_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [gcd_pkg::DENOM_BITS-1:0]       denom,
  input  logic [gcd_pkg::AMOUNT_BITS-1:0]      recip,
  input  gcd_pkg::load_t                       load,
  input  gcd_pkg::wave_t                       wave_in,
  output gcd_pkg::wave_t                       wave_out,
  output logic [gcd_pkg::COUNT_BITS-1:0]       pieces,
  output logic                                 empty
);

  localparam int AB = gcd_pkg::AMOUNT_BITS;
  localparam int CB = gcd_pkg::COUNT_BITS;
  localparam int CD = gcd_pkg::CD_BITS;
  localparam int WB = gcd_pkg::WIDE_BITS;
  localparam int PB = 2 * gcd_pkg::AMOUNT_BITS;

  // Control and till state
  logic          phase_r, phase_nxt;
  logic          go_r, go_nxt;
  logic [CB-1:0] count_r, count_nxt;
  logic [CD-1:0] cd_r, cd_nxt;

  // Working registers
  logic [AB-1:0] rem_r, rem_nxt;
  logic [PB-1:0] prod_r, prod_nxt;
  logic          all_r, all_nxt;
  logic [CD-1:0] cdm_r, cdm_nxt;
  logic [AB-1:0] rem_out_r, rem_out_nxt;
  logic [CB-1:0] pieces_r, pieces_nxt;

  logic [WB-1:0] denom_w, q0, qd, r0, qf, rf;
  logic          fix;

  // Finish the quotient: estimate is low by at most one
  always_comb begin
    denom_w = WB'(denom);
    q0      = WB'(prod_r[PB-1:AB]);
    qd      = q0 * denom_w;
    r0      = WB'(rem_r) - qd;
    fix     = (r0 >= denom_w);
    qf      = fix ? q0 + WB'(1) : q0;
    rf      = fix ? r0 - denom_w : r0;
  end

  // Next state: load, take the amount in, then pay out
  always_comb begin
    phase_nxt   = 1'b0;
    go_nxt      = 1'b0;
    count_nxt   = count_r;
    cd_nxt      = cd_r;
    rem_nxt     = rem_r;
    prod_nxt    = prod_r;
    all_nxt     = all_r;
    cdm_nxt     = cdm_r;
    rem_out_nxt = rem_out_r;
    pieces_nxt  = pieces_r;

    if (load.en) begin
      count_nxt = load.count;
      cd_nxt    = CD'(CD'(load.count) * CD'(denom));
    end

    if (wave_in.go) begin
      phase_nxt = 1'b1;
      rem_nxt   = wave_in.rem;
      prod_nxt  = PB'(wave_in.rem) * PB'(recip);
      all_nxt   = (WB'(wave_in.rem) >= WB'(cd_r));
      cdm_nxt   = CD'(WB'(cd_r) - WB'(wave_in.rem));
    end

    if (phase_r) begin
      go_nxt = 1'b1;
      if (all_r) begin
        // stock runs out: pay every piece held
        pieces_nxt  = count_r;
        rem_out_nxt = AB'(WB'(rem_r) - WB'(cd_r));
        count_nxt   = '0;
        cd_nxt      = '0;
      end else begin
        pieces_nxt  = qf[CB-1:0];
        rem_out_nxt = rf[AB-1:0];
        count_nxt   = count_r - qf[CB-1:0];
        cd_nxt      = CD'(WB'(cdm_r) + rf);
      end
    end
  end

  // Control and till registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      go_r    <= 1'b0;
      count_r <= '0;
      cd_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      go_r    <= go_nxt;
      count_r <= count_nxt;
      cd_r    <= cd_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    prod_r    <= prod_nxt;
    all_r     <= all_nxt;
    cdm_r     <= cdm_nxt;
    rem_out_r <= rem_out_nxt;
    pieces_r  <= pieces_nxt;
  end

  assign wave_out.go  = go_r;
  assign wave_out.rem = rem_out_r;
  assign pieces       = pieces_r;
  assign empty        = (count_r == '0);

endmodule

// File: hw/rtl/greedy_change_dispenser.sv
// Top level of the greedy change dispenser: request decode, cell chain, result register.
// Depends on gcd_pkg and gcd_cell.
//
//   channel  ports                      handshake
//   input    start, busy, in_data       taken when start is high and busy is low
//   result   out_valid, out_data        one cycle per word, always taken
//
// A load or an underpaid request gives its single word in the cycle after it is taken
// and leaves busy low. A change request walks eleven cells, each doing a reciprocal
// multiply, then a quotient fix and cap; each cell gives one result word, and busy
// stays high until the last cell is done. Synchronous reset empties the till.
module greedy_change_dispenser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gcd_pkg::in_word_t   in_data,
  output logic                out_valid,
  output gcd_pkg::out_word_t  out_data
);

  localparam int NS = gcd_pkg::NUM_SLOTS;
  localparam int SB = gcd_pkg::SLOT_BITS;
  localparam int CB = gcd_pkg::COUNT_BITS;
  localparam int AB = gcd_pkg::AMOUNT_BITS;

  gcd_pkg::run_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  gcd_pkg::out_word_t  out_data_r, out_data_nxt;

  logic                accept, underpaid;
  gcd_pkg::wave_t      wave [NS+1];
  gcd_pkg::load_t      load [NS];
  logic [CB-1:0]       cell_pieces [NS];
  logic [NS-1:0]       cell_empty;
  logic [NS-1:0]       cell_go;
  logic [SB-1:0]       sel_slot;
  logic [CB-1:0]       sel_pieces;
  logic [AB-1:0]       credit;

  assign accept    = start && !busy;
  assign underpaid = (in_data.offered < in_data.owed);

  // Launch the change amount into the first cell
  assign wave[0].go  = accept && (in_data.func == gcd_pkg::FUNC_CHANGE) && !underpaid;
  assign wave[0].rem = in_data.offered - in_data.owed;

  // Cell chain, one per denomination
  for (genvar i = 0; i < NS; i++) begin : g_cell
    assign load[i].en    = accept && (in_data.func == gcd_pkg::FUNC_LOAD) &&
                           (in_data.slot == SB'(i));
    assign load[i].count = in_data.count;
    assign cell_go[i]    = wave[i+1].go;

    gcd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .denom    (gcd_pkg::DENOM[i]),
      .recip    (gcd_pkg::RECIP[i]),
      .load     (load[i]),
      .wave_in  (wave[i]),
      .wave_out (wave[i+1]),
      .pieces   (cell_pieces[i]),
      .empty    (cell_empty[i])
    );
  end

  // Pick the cell that finished this cycle
  always_comb begin
    sel_slot   = '0;
    sel_pieces = '0;
    for (int i = 0; i < NS; i++) begin
      if (cell_go[i]) begin
        sel_slot   = sel_slot | SB'(i);
        sel_pieces = sel_pieces | cell_pieces[i];
      end
    end
  end

  assign credit = wave[NS].rem;

  // Next state and result word
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      gcd_pkg::S_IDLE: begin
        if (wave[0].go) begin
          state_nxt = gcd_pkg::S_RUN;
        end
      end
      gcd_pkg::S_RUN: begin
        if (wave[NS].go) begin
          state_nxt = gcd_pkg::S_IDLE;
        end
      end
      default: state_nxt = gcd_pkg::S_IDLE;
    endcase

    if (accept && (in_data.func == gcd_pkg::FUNC_LOAD)) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.denom_slot = in_data.slot;
      out_data_nxt.pieces     = (in_data.slot < SB'(NS)) ? in_data.count : '0;
      out_data_nxt.last       = 1'b1;
      out_data_nxt.status     = gcd_pkg::STATUS_LOADED;
      out_data_nxt.credit     = '0;
    end else if (accept && underpaid) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.denom_slot = '0;
      out_data_nxt.pieces     = '0;
      out_data_nxt.last       = 1'b1;
      out_data_nxt.status     = gcd_pkg::STATUS_UNDERPAID;
      out_data_nxt.credit     = '0;
    end else if (|cell_go) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.denom_slot = sel_slot;
      out_data_nxt.pieces     = sel_pieces;
      out_data_nxt.last       = wave[NS].go;
      out_data_nxt.status     = gcd_pkg::STATUS_EXACT;
      out_data_nxt.credit     = '0;
      if (wave[NS].go && (credit != '0)) begin
        out_data_nxt.status = (&cell_empty) ? gcd_pkg::STATUS_EMPTY
                                            : gcd_pkg::STATUS_LACKING;
        out_data_nxt.credit = credit;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r == gcd_pkg::S_RUN);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
